@@ src/tie_pkg.sv @@
// Shared types and constants for the tape-image to load-image converter.
package tie_pkg;

  typedef enum logic [18:0] {
    PH_HDR          = 19'h00001,
    PH_LEN_LO       = 19'h00002,
    PH_LEN_HI       = 19'h00004,
    PH_OB_TYPE      = 19'h00008,
    PH_OB_SZ_LO     = 19'h00010,
    PH_OB_SZ_HI     = 19'h00020,
    PH_TB_TYPE      = 19'h00040,
    PH_TB_INDEX     = 19'h00080,
    PH_ADDR_LO      = 19'h00100,
    PH_ADDR_HI      = 19'h00200,
    PH_COUNT        = 19'h00400,
    PH_DATA         = 19'h00800,
    PH_CHECK        = 19'h01000,
    PH_SKIP_ADDR_LO = 19'h02000,
    PH_SKIP_ADDR_HI = 19'h04000,
    PH_SKIP_COUNT   = 19'h08000,
    PH_SKIP_DATA    = 19'h10000,
    PH_AS_LO        = 19'h20000,
    PH_AS_HI        = 19'h40000
  } phase_t;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_HEADER     = 2'd1;
  localparam logic [1:0] ERR_OUTER_TYPE = 2'd2;
  localparam logic [1:0] ERR_TAPE_TYPE  = 2'd3;

  localparam logic [7:0] FILE_HDR     = 8'hFF;
  localparam logic [7:0] OUTER_INNER  = 8'h55;
  localparam logic [7:0] OUTER_FINAL  = 8'hAA;
  localparam logic [7:0] TB_CODE      = 8'hF1;
  localparam logic [7:0] LD_CODE      = 8'hD1;
  localparam logic [7:0] TB_SCREEN    = 8'hF5;
  localparam logic [7:0] LD_SCREEN    = 8'hD5;
  localparam logic [7:0] TB_MACHINE   = 8'hF9;
  localparam logic [7:0] LD_MACHINE   = 8'hD9;
  localparam logic [7:0] TB_AUTOSTART = 8'hB9;
  localparam logic [7:0] TB_NAME_A    = 8'h83;
  localparam logic [7:0] TB_NAME_B    = 8'h87;
  localparam logic [7:0] TB_BASIC     = 8'hF7;
  localparam logic [7:0] TB_END_A     = 8'hB1;
  localparam logic [7:0] TB_END_B     = 8'hB5;
  localparam logic [7:0] TB_END_C     = 8'hB7;
  localparam logic [7:0] OP_JUMP      = 8'hC3;
  localparam logic [7:0] OP_RETURN    = 8'hC9;

  localparam int unsigned BURST_MAX = 5;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      img_end;
    logic [1:0]                err;
  } burst_t;

endpackage

@@ src/tie_in_if.sv @@
// Channel carrying tape-image bytes into the converter.
interface tie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

@@ src/tie_out_if.sv @@
// Channel carrying converted load-image bytes out of the converter.
interface tie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       image_end;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output run_last, output image_end,
                  output error_code, input ready);
  modport sink (input valid, input out_byte, input run_last, input image_end,
                input error_code, output ready);
endinterface

@@ src/tape_image_to_load_image_converter.sv @@
// Top level of the tape-image to load-image converter.
//
//  Port   | Role   | Payload
//  -------+--------+--------------------------------------------
//  tape   | sink   | in_byte, file_start
//  image  | source | out_byte, run_last, image_end, error_code
//
// Each accepted byte is parsed in the cycle it is taken and its results, up to five,
// are held in a burst register that sends one result per cycle while the image side is ready.
// A new byte is taken once the burst register is empty or its last result is being taken;
// a burst of several results (five for a load header, three for a jump) holds the input
// back while it drains, and so does an image side that is not ready.
// The synchronous reset empties the burst register and halts the parser until a file start.
module tape_image_to_load_image_converter (
  input  logic     clk,
  input  logic     rst,
  tie_in_if.sink   tape,
  tie_out_if.source image
);
  import tie_pkg::*;

  burst_t parsed;
  burst_t pend, pend_next;
  logic   accept;
  logic   sent;

  assign sent       = image.valid && image.ready;
  assign tape.ready = (pend.cnt == 3'd0) || (pend.cnt == 3'd1 && image.ready);
  assign accept     = tape.valid && tape.ready;

  tie_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (tape.in_byte),
    .file_start (tape.file_start),
    .burst      (parsed)
  );

  always_comb begin
    pend_next = pend;
    if (accept && parsed.cnt != 3'd0) begin
      pend_next = parsed;
    end else if (sent) begin
      pend_next.bytes = {8'h00, pend.bytes[BURST_MAX-1:1]};
      pend_next.cnt   = pend.cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  assign image.valid      = (pend.cnt != 3'd0);
  assign image.out_byte   = pend.bytes[0];
  assign image.run_last   = (pend.cnt == 3'd1);
  assign image.image_end  = pend.img_end && (pend.cnt == 3'd1);
  assign image.error_code = pend.err;

`ifndef SYNTHESIS
  a_accept_only_when_draining: assert property (@(posedge clk) disable iff (rst)
    accept |-> (pend.cnt == 3'd0 || pend.cnt == 3'd1))
    else $error("Request accepted while a longer burst was pending.");

  a_burst_bounded: assert property (@(posedge clk) disable iff (rst)
    pend.cnt <= 3'd5)
    else $error("Burst count out of range.");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (image.valid && image.error_code != ERR_NONE) |-> (image.run_last && image.out_byte == 8'h00))
    else $error("Error result is not a single zero byte.");

  a_burst_shifts: assert property (@(posedge clk) disable iff (rst)
    (sent && !image.run_last) |=> (image.valid && pend.cnt == $past(pend.cnt) - 3'd1))
    else $error("Burst did not advance after a result was taken.");
`endif

endmodule

@@ src/tie_parser.sv @@
// Tape-image parser: block state and the result burst caused by one input byte.
module tie_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            file_start,
  output tie_pkg::burst_t burst
);
  import tie_pkg::*;

  phase_t      phase, phase_next, ph;
  logic [15:0] outer_left, outer_left_next, obl, obl_dec, chk_val;
  logic        outer_final, outer_final_next, fin;
  logic [7:0]  size_low, size_low_next, slo;
  logic [7:0]  mapped_type, mapped_type_next, mt;
  logic [15:0] load_addr, load_addr_next, la;
  logic [8:0]  payload_left, payload_left_next, pl, pl_dec;
  logic [15:0] autostart, autostart_next, as_addr;
  logic [1:0]  skip_flags, skip_flags_next, sf;
  logic        halted, halted_next, hlt;
  logic        chk_end;

  always_comb begin
    ph      = phase;
    obl     = outer_left;
    fin     = outer_final;
    slo     = size_low;
    mt      = mapped_type;
    la      = load_addr;
    pl      = payload_left;
    as_addr = autostart;
    sf      = skip_flags;
    hlt     = halted;
    if (file_start) begin
      ph      = PH_HDR;
      obl     = '0;
      fin     = 1'b0;
      slo     = '0;
      mt      = '0;
      la      = '0;
      pl      = '0;
      as_addr = '0;
      sf      = '0;
      hlt     = 1'b0;
    end

    obl_dec = obl;
    if (!hlt && (ph inside {PH_TB_TYPE, PH_TB_INDEX, PH_ADDR_LO, PH_ADDR_HI, PH_COUNT,
                            PH_DATA, PH_CHECK, PH_SKIP_ADDR_LO, PH_SKIP_ADDR_HI,
                            PH_SKIP_COUNT, PH_SKIP_DATA, PH_AS_LO, PH_AS_HI})
        && obl != '0) begin
      obl_dec = obl - 16'd1;
    end
    pl_dec = (pl != '0) ? pl - 9'd1 : '0;

    phase_next        = ph;
    outer_left_next   = obl_dec;
    outer_final_next  = fin;
    size_low_next     = slo;
    mapped_type_next  = mt;
    load_addr_next    = la;
    payload_left_next = pl;
    autostart_next    = as_addr;
    skip_flags_next   = sf;
    halted_next       = hlt;
    burst             = '0;
    chk_end           = 1'b0;
    chk_val           = obl_dec;

    if (!hlt) begin
      case (ph)
        PH_HDR: begin
          if (in_byte == FILE_HDR) begin
            phase_next = PH_LEN_LO;
          end else begin
            halted_next = 1'b1;
            burst.cnt   = 3'd1;
            burst.err   = ERR_HEADER;
          end
        end
        PH_LEN_LO: phase_next = PH_LEN_HI;
        PH_LEN_HI: phase_next = PH_OB_TYPE;
        PH_OB_TYPE: begin
          if (in_byte == OUTER_INNER || in_byte == OUTER_FINAL) begin
            outer_final_next = (in_byte == OUTER_FINAL);
            phase_next       = PH_OB_SZ_LO;
          end else begin
            halted_next = 1'b1;
            burst.cnt   = 3'd1;
            burst.err   = ERR_OUTER_TYPE;
          end
        end
        PH_OB_SZ_LO: begin
          size_low_next = in_byte;
          phase_next    = PH_OB_SZ_HI;
        end
        PH_OB_SZ_HI: begin
          outer_left_next = {in_byte, slo};
          chk_val         = {in_byte, slo};
          chk_end         = 1'b1;
        end
        PH_TB_TYPE: begin
          mapped_type_next = '0;
          skip_flags_next  = '0;
          phase_next       = PH_TB_INDEX;
          case (in_byte)
            TB_NAME_A, TB_NAME_B:           skip_flags_next = 2'b01;
            TB_BASIC:                       skip_flags_next = 2'b11;
            TB_END_A, TB_END_B, TB_END_C:   skip_flags_next = 2'b00;
            TB_CODE:                        mapped_type_next = LD_CODE;
            TB_SCREEN:                      mapped_type_next = LD_SCREEN;
            TB_MACHINE:                     mapped_type_next = LD_MACHINE;
            TB_AUTOSTART:                   mapped_type_next = TB_AUTOSTART;
            default: begin
              phase_next  = ph;
              halted_next = 1'b1;
              burst.cnt   = 3'd1;
              burst.err   = ERR_TAPE_TYPE;
            end
          endcase
        end
        PH_TB_INDEX: begin
          if (mt == TB_AUTOSTART) begin
            phase_next = PH_AS_LO;
          end else if (mt != '0) begin
            phase_next = PH_ADDR_LO;
          end else if (sf[1]) begin
            phase_next = PH_SKIP_ADDR_LO;
          end else if (sf[0]) begin
            phase_next = PH_SKIP_COUNT;
          end else begin
            phase_next = PH_CHECK;
          end
        end
        PH_ADDR_LO: begin
          load_addr_next = {8'h00, in_byte};
          phase_next     = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          load_addr_next = {in_byte, la[7:0]};
          phase_next     = PH_COUNT;
        end
        PH_COUNT: begin
          payload_left_next = (in_byte == '0) ? 9'd256 : {1'b0, in_byte};
          burst.bytes[0]    = mt;
          burst.bytes[1]    = la[7:0];
          burst.bytes[2]    = la[15:8];
          burst.bytes[3]    = in_byte;
          burst.bytes[4]    = (in_byte == '0) ? 8'h01 : 8'h00;
          burst.cnt         = 3'd5;
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          burst.bytes[0]    = in_byte;
          burst.cnt         = 3'd1;
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: chk_end = 1'b1;
        PH_SKIP_ADDR_LO: phase_next = PH_SKIP_ADDR_HI;
        PH_SKIP_ADDR_HI: phase_next = sf[0] ? PH_SKIP_COUNT : PH_CHECK;
        PH_SKIP_COUNT: begin
          payload_left_next = {1'b0, in_byte};
          phase_next        = (in_byte != '0) ? PH_SKIP_DATA : PH_CHECK;
        end
        PH_SKIP_DATA: begin
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_AS_LO: begin
          autostart_next = {as_addr[15:8], in_byte};
          phase_next     = PH_AS_HI;
        end
        PH_AS_HI: begin
          autostart_next = {in_byte, as_addr[7:0]};
          phase_next     = PH_CHECK;
        end
        default: begin
          halted_next = 1'b1;
          burst.cnt   = 3'd1;
          burst.err   = ERR_HEADER;
        end
      endcase

      if (chk_end) begin
        if (chk_val != '0) begin
          phase_next = PH_TB_TYPE;
        end else if (fin) begin
          halted_next   = 1'b1;
          phase_next    = PH_HDR;
          burst.img_end = 1'b1;
          if (as_addr != '0) begin
            burst.bytes[0] = OP_JUMP;
            burst.bytes[1] = as_addr[7:0];
            burst.bytes[2] = as_addr[15:8];
            burst.cnt      = 3'd3;
          end else begin
            burst.bytes[0] = OP_RETURN;
            burst.cnt      = 3'd1;
          end
        end else begin
          phase_next = PH_OB_TYPE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      outer_left   <= '0;
      outer_final  <= 1'b0;
      size_low     <= '0;
      mapped_type  <= '0;
      load_addr    <= '0;
      payload_left <= '0;
      autostart    <= '0;
      skip_flags   <= '0;
      halted       <= 1'b1;
    end else if (accept) begin
      phase        <= phase_next;
      outer_left   <= outer_left_next;
      outer_final  <= outer_final_next;
      size_low     <= size_low_next;
      mapped_type  <= mapped_type_next;
      load_addr    <= load_addr_next;
      payload_left <= payload_left_next;
      autostart    <= autostart_next;
      skip_flags   <= skip_flags_next;
      halted       <= halted_next;
    end
  end

endmodule
